@@ src/nearest_palette_color_cache_assert.svh @@
// Assertion macros for the nearest palette colour cache checker.
// Needs a clk and an arst_n in scope where the macros are used.
`ifndef NEAREST_PALETTE_COLOR_CACHE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_CACHE_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/npc_pkg.sv @@
// Shared types and constants for the nearest palette colour cache.
// No dependencies.
package npc_pkg;

	localparam int CACHE_ENTRIES_DEF   = 1024;
	localparam int PALETTE_ENTRIES_DEF = 256;

	localparam logic [31:0] HASH_MULT  = 32'd2654435761;
	localparam int          HASH_SHIFT = 22;

	localparam int COMP_W  = 8;
	localparam int KEY_W   = 3 * COMP_W;
	localparam int IDX_W   = 8;
	localparam int DIST_W  = 18;   // 3 * 255^2 fits
	localparam int EPOCH_W = 8;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_CHECK,
		ST_SEARCH,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	// side-band that travels alongside a palette entry through the distance unit
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
		logic [IDX_W-1:0]   answer;
	} cache_entry_t;

endpackage

@@ src/npc_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
// Used for both the palette table and the cache. No dependencies.
module npc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/npc_hash.sv @@
// Knuth multiplicative hash of the packed colour, product registered.
// Depends on npc_pkg.
module npc_hash
	import npc_pkg::*;
#(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
	parameter int SLOT_W        = 10
) (
	input  logic              clk,
	input  logic              en,
	input  logic [KEY_W-1:0]  key,
	output logic [SLOT_W-1:0] slot
);

	logic [31:0] prod_q;
	logic [31:0] prod_c;
	logic [31:0] shifted;

	assign prod_c = {{(32-KEY_W){1'b0}}, key} * HASH_MULT;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_c;
		end
	end

	assign shifted = prod_q >> HASH_SHIFT;
	assign slot    = SLOT_W'(shifted & 32'(CACHE_ENTRIES - 1));

endmodule

@@ src/npc_dist.sv @@
// Squared Euclidean distance unit, one palette entry per cycle, registered output.
// Depends on npc_pkg.
module npc_dist
	import npc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEY_W-1:0]  pixel,
	input  logic [KEY_W-1:0]  colour,
	input  dist_tag_t         tag_i,
	output logic [DIST_W-1:0] dist_s2,
	output dist_tag_t         tag_s2
);

	logic [COMP_W-1:0]   pr, pg, pb, cr, cg, cb;
	logic [COMP_W-1:0]   dr, dg, db;
	logic [2*COMP_W-1:0] sr, sg, sb;
	logic [DIST_W-1:0]   sum;

	assign {pr, pg, pb} = pixel;
	assign {cr, cg, cb} = colour;

	assign dr = (pr >= cr) ? (pr - cr) : (cr - pr);
	assign dg = (pg >= cg) ? (pg - cg) : (cg - pg);
	assign db = (pb >= cb) ? (pb - cb) : (cb - pb);

	assign sr = dr * dr;
	assign sg = dg * dg;
	assign sb = db * db;

	assign sum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		dist_s2 <= sum;
	end

endmodule

@@ src/nearest_palette_color_cache.sv @@
// Top level of the nearest palette colour cache: sequencer, palette and cache RAMs.
// Depends on npc_pkg, npc_ram, npc_hash and npc_dist.
//
// Items enter on start while busy is low and are never refused otherwise.
// Results appear for one cycle with done. The receiver cannot stall them, so
// capture them on that cycle. A load item (mode 0) writes one palette entry
// when its index is in range and invalidates the whole cache by bumping the
// epoch. It gives no result. A lookup item (mode 1) hashes the colour into a
// direct-mapped cache slot. A hit passes through the HASH and CHECK states
// to the registered result, and busy drops together with done. A miss walks
// the palette one entry per cycle through the distance unit. The single
// palette read port and the one distance unit set this pace. A miss keeps busy
// high through the SEARCH, DRAIN and WRITE states; in WRITE the slot is
// overwritten and the result registered. Cache validity is an epoch tag kept
// in each cache word, and a load bumps the epoch. A clearing pass over all
// CACHE_ENTRIES slots zeroes the tags with busy held high. It runs after
// reset, and after every 255th load when the epoch wraps. All palette entries
// must be loaded before the first lookup. Ties go to the lowest index.
module nearest_palette_color_cache
	import npc_pkg::*;
#(
	parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [COMP_W-1:0] red,
	input  logic [COMP_W-1:0] green,
	input  logic [COMP_W-1:0] blue,
	output logic              done,
	output logic [IDX_W-1:0]  palette_index,
	output logic              cache_hit
);

	localparam int SLOT_W  = $clog2(CACHE_ENTRIES);
	localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
	localparam int ENTRY_W = $bits(cache_entry_t);

	state_t state_q, state_d;

	// control registers
	logic [SLOT_W-1:0]  clr_cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [PAL_AW-1:0]  cnt_q;
	dist_tag_t          tag_s1;
	logic               done_q;

	// payload registers
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DIST_W-1:0] min_sq_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  palette_index_q;
	logic              cache_hit_q;

	logic               accept;
	logic               accept_load;
	logic               accept_lookup;
	logic [EPOCH_W-1:0] epoch_inc;
	logic               epoch_wrap;
	logic               clr_last;
	logic               issue;
	logic               issue_last;
	logic               hit;
	logic               better;
	logic               search_end;

	logic [KEY_W-1:0]  in_key;
	logic [SLOT_W-1:0] hash_slot;

	logic              pal_we;
	logic              pal_re;
	logic [KEY_W-1:0]  pal_rdata;

	logic               cache_we;
	logic [SLOT_W-1:0]  cache_waddr;
	cache_entry_t       cache_wdata;
	logic               cache_re;
	logic [ENTRY_W-1:0] cache_rdata;
	cache_entry_t       cache_rd;

	logic [DIST_W-1:0] dist_s2;
	dist_tag_t         tag_s2;

	assign accept        = start && !busy;
	assign accept_load   = accept && (mode == MODE_LOAD);
	assign accept_lookup = accept && (mode == MODE_LOOKUP);
	assign in_key        = {red, green, blue};

	assign epoch_inc  = epoch_q + EPOCH_W'(1);
	assign epoch_wrap = (epoch_inc == '0);
	assign clr_last   = (clr_cnt_q == SLOT_W'(CACHE_ENTRIES - 1));
	assign issue_last = (cnt_q == PAL_AW'(PALETTE_ENTRIES - 1));

	assign cache_rd = cache_entry_t'(cache_rdata);
	assign hit      = (cache_rd.epoch == epoch_q) && (cache_rd.key == key_q);

	// strict less keeps the lowest index on a tie
	assign better     = tag_s2.vld && (dist_s2 < min_sq_q);
	assign search_end = tag_s2.vld && tag_s2.last;

	// loads beyond the palette size write nothing but still invalidate
	assign pal_we = accept_load &&
		({1'b0, entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

	// ---------------------------------------------------------------
	// Next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept_lookup) begin
					state_d = ST_HASH;
				end else if (accept_load && epoch_wrap) begin
					state_d = ST_CLEAR;
				end
			end
			ST_HASH: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = hit ? ST_IDLE : ST_SEARCH;
			end
			ST_SEARCH: begin
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (search_end) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// ---------------------------------------------------------------
	// State outputs
	// ---------------------------------------------------------------
	always_comb begin
		busy        = 1'b1;
		issue       = 1'b0;
		pal_re      = 1'b0;
		cache_re    = 1'b0;
		cache_we    = 1'b0;
		cache_waddr = slot_q;
		cache_wdata = '{epoch: epoch_q, key: key_q, answer: best_idx_q};
		unique case (state_q)
			ST_CLEAR: begin
				cache_we    = 1'b1;
				cache_waddr = clr_cnt_q;
				cache_wdata = '0;
			end
			ST_IDLE: busy = 1'b0;
			ST_HASH: cache_re = 1'b1;
			ST_CHECK: ;
			ST_SEARCH: begin
				issue  = 1'b1;
				pal_re = 1'b1;
			end
			ST_DRAIN: ;
			ST_WRITE: cache_we = 1'b1;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			epoch_q   <= EPOCH_W'(1);
			cnt_q     <= '0;
			tag_s1    <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == ST_CHECK) && hit) || (state_q == ST_WRITE);

			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + SLOT_W'(1);
				// tag 0 is what the pass writes, so live epochs start at 1
				if (clr_last) begin
					epoch_q <= EPOCH_W'(1);
				end
			end else if (accept_load) begin
				epoch_q <= epoch_inc;
			end

			if (state_q == ST_CHECK) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + PAL_AW'(1);
			end

			tag_s1.vld  <= issue;
			tag_s1.last <= issue && issue_last;
			tag_s1.idx  <= IDX_W'(cnt_q);
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept_lookup) begin
			key_q <= in_key;
		end
		if (state_q == ST_HASH) begin
			slot_q <= hash_slot;
		end

		if (state_q == ST_CHECK) begin
			min_sq_q   <= '1;
			best_idx_q <= '0;
		end else if (better) begin
			min_sq_q   <= dist_s2;
			best_idx_q <= tag_s2.idx;
		end

		if (state_q == ST_CHECK && hit) begin
			palette_index_q <= cache_rd.answer;
			cache_hit_q     <= 1'b1;
		end else if (state_q == ST_WRITE) begin
			palette_index_q <= best_idx_q;
			cache_hit_q     <= 1'b0;
		end
	end

	assign done          = done_q;
	assign palette_index = palette_index_q;
	assign cache_hit     = cache_hit_q;

	// ---------------------------------------------------------------
	// Datapath parts
	// ---------------------------------------------------------------
	npc_hash #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.SLOT_W       (SLOT_W)
	) u_hash (
		.clk (clk),
		.en  (accept_lookup),
		.key (in_key),
		.slot(hash_slot)
	);

	npc_ram #(
		.DEPTH(PALETTE_ENTRIES),
		.WIDTH(KEY_W),
		.AW   (PAL_AW)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(entry_index[PAL_AW-1:0]),
		.wdata(in_key),
		.re   (pal_re),
		.raddr(cnt_q),
		.rdata(pal_rdata)
	);

	npc_ram #(
		.DEPTH(CACHE_ENTRIES),
		.WIDTH(ENTRY_W),
		.AW   (SLOT_W)
	) u_cache (
		.clk  (clk),
		.we   (cache_we),
		.waddr(cache_waddr),
		.wdata(ENTRY_W'(cache_wdata)),
		.re   (cache_re),
		.raddr(hash_slot),
		.rdata(cache_rdata)
	);

	npc_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (key_q),
		.colour (pal_rdata),
		.tag_i  (tag_s1),
		.dist_s2(dist_s2),
		.tag_s2 (tag_s2)
	);

endmodule

@@ src/npc_checker.sv @@
// Port-level checker for the nearest palette colour cache, bound to the top level.
// Depends on nearest_palette_color_cache_assert.svh.
`include "nearest_palette_color_cache_assert.svh"

module npc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done
);

	`NPC_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a busy cycle before it")
	`NPC_ASSERT_NXT(a_done_single, done, !done, "result strobe held for two cycles")
	`NPC_ASSERT_NXT(a_lookup_busy, start && !busy && mode, busy, "lookup accepted but not busy")
	`NPC_ASSERT_NXT(a_load_silent, start && !busy && !mode, !done, "load item gave a result")

endmodule

bind nearest_palette_color_cache npc_checker u_npc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.mode  (mode),
	.done  (done)
);
